// File: hw/rtl/rmfh_pkg.sv
// Shared types and codes for the recursive mutex lock manager.
// No dependencies; imported by every module of the block.
package rmfh_pkg;

    // Width of the nesting counter and of the nest_depth field
    localparam int NEST_W = 8;

    // Request kinds carried on the input tuser bit
    localparam logic ACTION_ACQUIRE = 1'b0;
    localparam logic ACTION_RELEASE = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NEST_LIMIT = 2'd1;
    localparam logic [1:0] STATUS_NOT_HOLDER = 2'd2;
    localparam logic [1:0] STATUS_QUEUE_FULL = 2'd3;

    // Bit positions of the fixed-width result fields in m_tdata
    localparam int RES_STATUS_LSB = 0;
    localparam int RES_GRANTED    = 2;
    localparam int RES_QUEUED     = 3;
    localparam int RES_WAKE_VALID = 4;
    localparam int RES_WAKE_LSB   = 5;

    // Commands from the lock controller to the wait queue
    typedef struct packed {
        logic push;
        logic pop;
    } queue_cmd_t;

    // Occupancy flags from the wait queue
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

// File: hw/rtl/rmfh_wait_queue.sv
// FIFO of waiting thread ids: memory, head/tail pointers and fill count.
// The head entry is prefetched into a register. Depends on rmfh_pkg.
module rmfh_wait_queue #(
    parameter int THREAD_ID_BITS = 8,
    parameter int WAIT_DEPTH     = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rmfh_pkg::queue_cmd_t      cmd,
    input  logic [THREAD_ID_BITS-1:0] push_id,
    output logic [THREAD_ID_BITS-1:0] head_id,
    output rmfh_pkg::queue_stat_t     stat
);
    import rmfh_pkg::*;

    localparam int PTR_W = $clog2(WAIT_DEPTH);
    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WAIT_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WAIT_DEPTH);

    logic [THREAD_ID_BITS-1:0] mem [WAIT_DEPTH];

    logic [PTR_W-1:0]          head_reg, head_next;
    logic [PTR_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [THREAD_ID_BITS-1:0] head_rd_reg;
    logic                      bypass_reg, bypass_next;
    logic [THREAD_ID_BITS-1:0] bypass_id_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.push) begin
            tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop) begin
            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        // a write landing on the slot being fetched must be forwarded
        bypass_next = cmd.push && (tail_reg == head_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            bypass_reg <= bypass_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_reg] <= push_id;
        end
        head_rd_reg   <= mem[head_next];
        bypass_id_reg <= push_id;
    end

    assign head_id    = bypass_reg ? bypass_id_reg : head_rd_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);

endmodule

// File: hw/rtl/rmfh_lock_ctrl.sv
// Owner, nesting count and grant/queue/handoff decision for one request.
// Drives the wait queue commands. Depends on rmfh_pkg.
module rmfh_lock_ctrl #(
    parameter int THREAD_ID_BITS = 8,
    parameter int MAX_NEST       = 255
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_valid,
    input  logic                        action,
    input  logic [THREAD_ID_BITS-1:0]   tid,
    input  logic                        recursive,
    input  rmfh_pkg::queue_stat_t       q_stat,
    input  logic [THREAD_ID_BITS-1:0]   q_head_id,
    output rmfh_pkg::queue_cmd_t        q_cmd,
    output logic [1:0]                  status,
    output logic                        granted,
    output logic                        queued,
    output logic                        wake_valid,
    output logic [THREAD_ID_BITS-1:0]   wake_thread,
    output logic [rmfh_pkg::NEST_W-1:0] nest_depth
);
    import rmfh_pkg::*;

    localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NEST);
    localparam logic [NEST_W-1:0] NEST_ONE = NEST_W'(1);

    logic                      holder_valid_reg, holder_valid_next;
    logic [THREAD_ID_BITS-1:0] holder_id_reg, holder_id_next;
    logic [NEST_W-1:0]         nest_reg, nest_next;
    logic [NEST_W-1:0]         limit;
    logic                      is_holder;

    always_comb begin
        holder_valid_next = holder_valid_reg;
        holder_id_next    = holder_id_reg;
        nest_next         = nest_reg;
        q_cmd             = '0;
        status            = STATUS_OK;
        granted           = 1'b0;
        queued            = 1'b0;
        wake_valid        = 1'b0;
        wake_thread       = '0;
        limit             = recursive ? NEST_MAX : NEST_ONE;
        is_holder         = holder_valid_reg && (holder_id_reg == tid);

        if (action == ACTION_ACQUIRE) begin
            if (is_holder) begin
                granted = 1'b1;
                if (nest_reg < limit) begin
                    nest_next = nest_reg + 1'b1;
                end else begin
                    status = STATUS_NEST_LIMIT;
                end
            end else if (!holder_valid_reg) begin
                holder_valid_next = 1'b1;
                holder_id_next    = tid;
                nest_next         = NEST_ONE;
                granted           = 1'b1;
            end else if (!q_stat.full) begin
                q_cmd.push = 1'b1;
                queued     = 1'b1;
            end else begin
                status = STATUS_QUEUE_FULL;
            end
        end else begin
            if (!is_holder) begin
                status = STATUS_NOT_HOLDER;
            end else if (nest_reg > NEST_ONE) begin
                nest_next = nest_reg - 1'b1;
            end else if (!q_stat.empty) begin
                // hand ownership straight to the oldest waiter
                holder_id_next = q_head_id;
                nest_next      = NEST_ONE;
                q_cmd.pop      = 1'b1;
                wake_valid     = 1'b1;
                wake_thread    = q_head_id;
            end else begin
                holder_valid_next = 1'b0;
                nest_next         = '0;
            end
        end

        nest_depth = holder_valid_next ? nest_next : '0;

        // hold all state when no transaction advances
        if (!item_valid) begin
            holder_valid_next = holder_valid_reg;
            holder_id_next    = holder_id_reg;
            nest_next         = nest_reg;
            q_cmd             = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holder_valid_reg <= 1'b0;
            holder_id_reg    <= '0;
            nest_reg         <= '0;
        end else begin
            holder_valid_reg <= holder_valid_next;
            holder_id_reg    <= holder_id_next;
            nest_reg         <= nest_next;
        end
    end

endmodule

// File: hw/rtl/recursive_mutex_fifo_handoff_core.sv
// Top level of the recursive mutex lock manager with FIFO wait queue.
// Depends on rmfh_pkg, rmfh_lock_ctrl and rmfh_wait_queue.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser is the action (0 acquire,
//   1 release), s_tdata carries the thread id. Every request produces
//   exactly one result on the m_ stream, in request order.
//   cfg_we/cfg_wdata set the recursive bit; write it only while idle.
// Timing:
//   A request is registered in the input register on acceptance and its result
//   is then registered in the output register, which drives m_tvalid.
//   One request per cycle is sustained while m_tready stays high: lock state
//   and queue pointers are updated together, and the queue head is prefetched
//   from the wait memory so that a handoff needs no separate read.
// Reset:
//   aresetn low frees the lock, empties the wait queue, clears the
//   recursive bit and drops both valid flags. No clearing pass is needed.
// Stall:
//   While m_tready is low the result holds; one more request is taken into
//   the input register, then s_tready drops until the result drains.
module recursive_mutex_fifo_handoff_core #(
    parameter int THREAD_ID_BITS = 8,
    parameter int WAIT_DEPTH     = 16,
    parameter int MAX_NEST       = 255
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // configuration
    input  logic                                          cfg_we,
    input  logic                                          cfg_wdata,
    // request stream
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // tdata: thread_id
    input  logic [((THREAD_ID_BITS + 7) / 8) * 8 - 1:0]   s_tdata,
    // tuser: action
    input  logic                                          s_tuser,
    // result stream
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // tdata: status[1:0], granted, queued, wake_valid, wake_thread, nest_depth
    output logic [((THREAD_ID_BITS + 20) / 8) * 8 - 1:0]  m_tdata
);
    import rmfh_pkg::*;

    localparam int M_TDATA_W = ((THREAD_ID_BITS + 20) / 8) * 8;
    localparam int NEST_LSB  = RES_WAKE_LSB + THREAD_ID_BITS;

    logic                      recursive_reg;
    logic                      in_valid_reg;
    logic                      in_action_reg;
    logic [THREAD_ID_BITS-1:0] in_tid_reg;
    logic                      out_valid_reg;
    logic [M_TDATA_W-1:0]      out_data_reg, out_data_next;
    logic                      advance;
    logic                      s_accept;

    queue_cmd_t                q_cmd;
    queue_stat_t               q_stat;
    logic [THREAD_ID_BITS-1:0] q_head_id;

    logic [1:0]                res_status;
    logic                      res_granted;
    logic                      res_queued;
    logic                      res_wake_valid;
    logic [THREAD_ID_BITS-1:0] res_wake_thread;
    logic [NEST_W-1:0]         res_nest_depth;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recursive_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                recursive_reg <= cfg_wdata;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_tuser;
            in_tid_reg    <= s_tdata[THREAD_ID_BITS-1:0];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    rmfh_lock_ctrl #(
        .THREAD_ID_BITS (THREAD_ID_BITS),
        .MAX_NEST       (MAX_NEST)
    ) u_lock_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (advance),
        .action      (in_action_reg),
        .tid         (in_tid_reg),
        .recursive   (recursive_reg),
        .q_stat      (q_stat),
        .q_head_id   (q_head_id),
        .q_cmd       (q_cmd),
        .status      (res_status),
        .granted     (res_granted),
        .queued      (res_queued),
        .wake_valid  (res_wake_valid),
        .wake_thread (res_wake_thread),
        .nest_depth  (res_nest_depth)
    );

    rmfh_wait_queue #(
        .THREAD_ID_BITS (THREAD_ID_BITS),
        .WAIT_DEPTH     (WAIT_DEPTH)
    ) u_wait_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (q_cmd),
        .push_id (in_tid_reg),
        .head_id (q_head_id),
        .stat    (q_stat)
    );

    always_comb begin
        out_data_next                                    = '0;
        out_data_next[RES_STATUS_LSB +: 2]               = res_status;
        out_data_next[RES_GRANTED]                       = res_granted;
        out_data_next[RES_QUEUED]                        = res_queued;
        out_data_next[RES_WAKE_VALID]                    = res_wake_valid;
        out_data_next[RES_WAKE_LSB +: THREAD_ID_BITS]    = res_wake_thread;
        out_data_next[NEST_LSB +: NEST_W]                = res_nest_depth;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hw/rtl/rmfh_checker.sv
// Port-level checks for the recursive mutex lock manager, bound to the top.
// Depends on rmfh_pkg and recursive_mutex_fifo_handoff_core.
module rmfh_checker #(
    parameter int THREAD_ID_BITS = 8
) (
    input logic                                         aclk,
    input logic                                         aresetn,
    input logic                                         m_tvalid,
    input logic                                         m_tready,
    input logic [((THREAD_ID_BITS + 20) / 8) * 8 - 1:0] m_tdata
);
    import rmfh_pkg::*;

    localparam int NEST_LSB = RES_WAKE_LSB + THREAD_ID_BITS;

    logic [1:0]        chk_status;
    logic              chk_granted;
    logic              chk_queued;
    logic              chk_wake;
    logic [NEST_W-1:0] chk_nest;

    assign chk_status  = m_tdata[RES_STATUS_LSB +: 2];
    assign chk_granted = m_tdata[RES_GRANTED];
    assign chk_queued  = m_tdata[RES_QUEUED];
    assign chk_wake    = m_tdata[RES_WAKE_VALID];
    assign chk_nest    = m_tdata[NEST_LSB +: NEST_W];

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a handoff leaves the new owner at depth one with an ok status
    a_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_wake |->
            chk_nest == NEST_W'(1) && chk_status == STATUS_OK
            && !chk_granted && !chk_queued)
        else $error("bad handoff result");

    // a queued request means somebody else holds the lock
    a_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_queued |->
            !chk_granted && chk_nest != '0 && chk_status == STATUS_OK)
        else $error("queued while lock free or granted");

    // a rejected release or a full queue reports no ownership change
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_status == STATUS_NOT_HOLDER || chk_status == STATUS_QUEUE_FULL)
            |-> !chk_granted && !chk_queued && !chk_wake)
        else $error("rejected request changed ownership");

    // granted always leaves the lock held
    a_granted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_granted |-> chk_nest != '0)
        else $error("granted with lock free");

endmodule

bind recursive_mutex_fifo_handoff_core rmfh_checker #(
    .THREAD_ID_BITS (THREAD_ID_BITS)
) u_rmfh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
